// ===== rtl/core/dmp_pkg.sv =====
// ---------------------------------------------------------------------------
// dmp_pkg
// shared types and constants for the dns message parser
// ---------------------------------------------------------------------------
package dmp_pkg;

    localparam int DefMaxQuestions = 8;
    localparam int DefOffsetBits   = 14;
    localparam logic [13:0] PtrMask = 14'h3fff;
    localparam logic [13:0] HeaderLast = 14'd11;

    localparam logic [2:0] KIND_HEADER   = 3'd0;
    localparam logic [2:0] KIND_NAME     = 3'd1;
    localparam logic [2:0] KIND_QUESTION = 3'd2;
    localparam logic [2:0] KIND_ANSWER   = 3'd3;
    localparam logic [2:0] KIND_DATA     = 3'd4;
    localparam logic [2:0] KIND_ERROR    = 3'd5;

    localparam logic [1:0] ERR_NONE      = 2'd0;
    localparam logic [1:0] ERR_NO_MATCH  = 2'd1;
    localparam logic [1:0] ERR_TRUNCATED = 2'd2;

    typedef struct packed {
        logic [2:0]  record_kind;
        logic [1:0]  error_code;
        logic [31:0] header_word;
        logic [63:0] section_counts;
        logic [15:0] record_type;
        logic [15:0] record_class;
        logic [31:0] time_to_live;
        logic [15:0] data_length;
        logic [2:0]  question_index;
        logic [7:0]  payload_byte;
        logic        last_of_run;
    } result_t;

endpackage

// ===== rtl/core/dns_message_parser.sv =====
// ---------------------------------------------------------------------------
// dns_message_parser
// streaming dns message parser, one byte per transfer
// ---------------------------------------------------------------------------
// input channel: in_valid/in_ready with data_byte and end_of_message, one
//   message byte per transfer in wire order
// output channel: out_valid/out_ready with one result per transfer; header,
//   name characters, questions, answers, data bytes and errors
// throughput: one byte per cycle while out_ready holds; every byte updates
//   the parser state in the cycle it is accepted
// output path: a result is registered in the parser and then written to a four
//   entry queue, from which it shows at the output
// stall: when out_ready is low the queue fills and in_ready drops once three
//   results wait; bytes that make no result still need the queue space check
// reset: parser returns to the header phase with counters cleared and the
//   queue empties; the question offset table is not cleared and is only read
//   for entries written in the current message
// ---------------------------------------------------------------------------
module dns_message_parser
    import dmp_pkg::*;
#(
    parameter int MAX_QUESTIONS = DefMaxQuestions,
    parameter int OFFSET_BITS   = DefOffsetBits
)
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic        in_valid,
    output logic        in_ready,
    input  logic [7:0]  data_byte,
    input  logic        end_of_message,
    output logic        out_valid,
    input  logic        out_ready,
    output logic [2:0]  record_kind,
    output logic [1:0]  error_code,
    output logic [31:0] header_word,
    output logic [63:0] section_counts,
    output logic [15:0] record_type,
    output logic [15:0] record_class,
    output logic [31:0] time_to_live,
    output logic [15:0] data_length,
    output logic [2:0]  question_index,
    output logic [7:0]  payload_byte,
    output logic        last_of_run
);

    logic    in_fire, res_valid, almost_full;
    result_t res, q;

    assign in_ready = !almost_full;
    assign in_fire  = in_valid && in_ready;

    dmp_front #(
        .MAX_QUESTIONS(MAX_QUESTIONS),
        .OFFSET_BITS  (OFFSET_BITS)
    ) u_front (
        .clk           (clk),
        .rst_n         (rst_n),
        .in_fire       (in_fire),
        .data_byte     (data_byte),
        .end_of_message(end_of_message),
        .res_valid     (res_valid),
        .res           (res)
    );

    dmp_queue u_queue (
        .clk        (clk),
        .rst_n      (rst_n),
        .push       (res_valid),
        .push_data  (res),
        .pop_valid  (out_valid),
        .pop        (out_ready),
        .pop_data   (q),
        .almost_full(almost_full)
    );

    assign record_kind    = q.record_kind;
    assign error_code     = q.error_code;
    assign header_word    = q.header_word;
    assign section_counts = q.section_counts;
    assign record_type    = q.record_type;
    assign record_class   = q.record_class;
    assign time_to_live   = q.time_to_live;
    assign data_length    = q.data_length;
    assign question_index = q.question_index;
    assign payload_byte   = q.payload_byte;
    assign last_of_run    = q.last_of_run;

endmodule

// ===== rtl/core/dmp_front.sv =====
// ---------------------------------------------------------------------------
// dmp_front
// byte parser: tracks phase and counters, builds at most one result per byte
// ---------------------------------------------------------------------------
module dmp_front
    import dmp_pkg::*;
#(
    parameter int MAX_QUESTIONS = DefMaxQuestions,
    parameter int OFFSET_BITS   = DefOffsetBits
)
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic        in_fire,
    input  logic [7:0]  data_byte,
    input  logic        end_of_message,
    output logic        res_valid,
    output result_t     res
);

    localparam int QW = (MAX_QUESTIONS > 1) ? $clog2(MAX_QUESTIONS) : 1;

    typedef enum logic [8:0] {
        PH_HEADER = 9'b000000001,
        PH_QLEN   = 9'b000000010,
        PH_QCHAR  = 9'b000000100,
        PH_QFIXED = 9'b000001000,
        PH_APTR   = 9'b000010000,
        PH_AFIXED = 9'b000100000,
        PH_ADATA  = 9'b001000000,
        PH_DONE   = 9'b010000000,
        PH_ERROR  = 9'b100000000
    } phase_t;

    phase_t                 phase_reg, phase_next;
    logic [OFFSET_BITS-1:0] offset_reg, offset_next;
    logic [3:0]             fcount_reg, fcount_next;
    logic [7:0]             label_reg, label_next;
    logic                   first_reg, first_next;
    logic [15:0]            qleft_reg, qleft_next;
    logic [15:0]            aleft_reg, aleft_next;
    logic [15:0]            dleft_reg, dleft_next;
    logic [31:0]            hdr_reg, hdr_next;
    logic [63:0]            cnt_reg, cnt_next;
    logic [63:0]            acc_reg, acc_next;
    logic [OFFSET_BITS-1:0] qstart_mem [MAX_QUESTIONS];

    logic [15:0]  qtotal, qidx, dec_d;
    logic         tbl_we;
    logic         found;
    logic [QW-1:0] hit_idx;
    logic [13:0]  ptr;
    logic [63:0]  acc_sh;
    logic         rv;
    result_t      r;

    assign qtotal = cnt_reg[63:48];
    assign qidx   = qtotal - qleft_reg;
    assign acc_sh = {acc_reg[55:0], data_byte};
    assign ptr    = acc_sh[13:0] & PtrMask;
    assign dec_d  = dleft_reg - 16'd1;

    // pointer match against stored question offsets, lowest question index wins
    always_comb
    begin
        found   = 1'b0;
        hit_idx = '0;
        for (int i = MAX_QUESTIONS - 1; i >= 0; i--)
        begin
            if (32'(i) < 32'(qtotal) &&
                14'(qstart_mem[i]) == ptr)
            begin
                found   = 1'b1;
                hit_idx = QW'(i);
            end
        end
    end

    always_comb
    begin
        phase_next  = phase_reg;
        offset_next = offset_reg + OFFSET_BITS'(1);
        fcount_next = fcount_reg;
        label_next  = label_reg;
        first_next  = first_reg;
        qleft_next  = qleft_reg;
        aleft_next  = aleft_reg;
        dleft_next  = dleft_reg;
        hdr_next    = hdr_reg;
        cnt_next    = cnt_reg;
        acc_next    = acc_reg;
        tbl_we      = 1'b0;
        rv          = 1'b0;
        r           = '0;
        case (phase_reg)
            PH_HEADER:
            begin
                if (offset_reg < OFFSET_BITS'(4))
                    hdr_next = {hdr_reg[23:0], data_byte};
                else
                    cnt_next = {cnt_reg[55:0], data_byte};
                if (14'(offset_reg) == HeaderLast)
                begin
                    rv               = 1'b1;
                    r.record_kind    = KIND_HEADER;
                    r.header_word    = hdr_reg;
                    r.section_counts = cnt_next;
                    qleft_next       = cnt_next[63:48];
                    aleft_next       = cnt_next[47:32];
                    fcount_next      = '0;
                    acc_next         = '0;
                    if (cnt_next[63:48] != 16'd0)
                    begin
                        phase_next = PH_QLEN;
                        first_next = 1'b1;
                    end
                    else if (cnt_next[47:32] != 16'd0)
                        phase_next = PH_APTR;
                    else
                        phase_next = PH_DONE;
                end
            end
            PH_QLEN:
            begin
                tbl_we     = first_reg && (32'(qidx) < 32'(MAX_QUESTIONS));
                first_next = 1'b0;
                if (data_byte == 8'd0)
                begin
                    phase_next  = PH_QFIXED;
                    fcount_next = '0;
                    acc_next    = '0;
                end
                else
                begin
                    if (!first_reg)
                    begin
                        rv               = 1'b1;
                        r.record_kind    = KIND_NAME;
                        r.question_index = qidx[2:0];
                        r.payload_byte   = 8'h2e;
                    end
                    label_next = data_byte;
                    phase_next = PH_QCHAR;
                end
            end
            PH_QCHAR:
            begin
                rv               = 1'b1;
                r.record_kind    = KIND_NAME;
                r.question_index = qidx[2:0];
                r.payload_byte   = data_byte;
                label_next       = label_reg - 8'd1;
                if (label_reg == 8'd1)
                    phase_next = PH_QLEN;
            end
            PH_QFIXED:
            begin
                acc_next    = acc_sh;
                fcount_next = fcount_reg + 4'd1;
                if (fcount_reg == 4'd3)
                begin
                    rv               = 1'b1;
                    r.record_kind    = KIND_QUESTION;
                    r.record_type    = acc_sh[31:16];
                    r.record_class   = acc_sh[15:0];
                    r.question_index = qidx[2:0];
                    qleft_next       = qleft_reg - 16'd1;
                    fcount_next      = '0;
                    acc_next         = '0;
                    if (qleft_reg != 16'd1)
                    begin
                        phase_next = PH_QLEN;
                        first_next = 1'b1;
                    end
                    else if (aleft_reg != 16'd0)
                        phase_next = PH_APTR;
                    else
                        phase_next = PH_DONE;
                end
            end
            PH_APTR:
            begin
                acc_next    = acc_sh;
                fcount_next = fcount_reg + 4'd1;
                if (fcount_reg == 4'd1)
                begin
                    fcount_next = '0;
                    acc_next    = '0;
                    if (!found)
                    begin
                        phase_next   = PH_ERROR;
                        rv           = 1'b1;
                        r.record_kind = KIND_ERROR;
                        r.error_code = ERR_NO_MATCH;
                    end
                    else
                    begin
                        label_next = 8'(hit_idx);
                        dleft_next = '0;
                        phase_next = PH_AFIXED;
                    end
                end
            end
            PH_AFIXED:
            begin
                if (fcount_reg < 4'd8)
                    acc_next = acc_sh;
                else
                    dleft_next = {dleft_reg[7:0], data_byte};
                fcount_next = fcount_reg + 4'd1;
                if (fcount_reg == 4'd9)
                begin
                    rv               = 1'b1;
                    r.record_kind    = KIND_ANSWER;
                    r.record_type    = acc_reg[63:48];
                    r.record_class   = acc_reg[47:32];
                    r.time_to_live   = acc_reg[31:0];
                    r.data_length    = dleft_next;
                    r.question_index = label_reg[2:0];
                    fcount_next      = '0;
                    if (dleft_next != 16'd0)
                        phase_next = PH_ADATA;
                    else
                    begin
                        aleft_next = aleft_reg - 16'd1;
                        acc_next   = '0;
                        phase_next = (aleft_reg != 16'd1) ? PH_APTR : PH_DONE;
                    end
                end
            end
            PH_ADATA:
            begin
                dleft_next       = dec_d;
                rv               = 1'b1;
                r.record_kind    = KIND_DATA;
                r.question_index = label_reg[2:0];
                r.payload_byte   = data_byte;
                r.last_of_run    = (dec_d == 16'd0);
                if (dec_d == 16'd0)
                begin
                    aleft_next  = aleft_reg - 16'd1;
                    fcount_next = '0;
                    acc_next    = '0;
                    phase_next  = (aleft_reg != 16'd1) ? PH_APTR : PH_DONE;
                end
            end
            default:
            begin
            end
        endcase

        if (end_of_message)
        begin
            if (phase_next != PH_DONE && phase_next != PH_ERROR)
            begin
                rv           = 1'b1;
                r            = '0;
                r.record_kind = KIND_ERROR;
                r.error_code = ERR_TRUNCATED;
            end
            phase_next  = PH_HEADER;
            offset_next = '0;
            fcount_next = '0;
            label_next  = '0;
            first_next  = 1'b1;
            qleft_next  = '0;
            aleft_next  = '0;
            dleft_next  = '0;
            hdr_next    = '0;
            cnt_next    = '0;
            acc_next    = '0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            phase_reg  <= PH_HEADER;
            offset_reg <= '0;
            fcount_reg <= '0;
            label_reg  <= '0;
            first_reg  <= 1'b1;
            qleft_reg  <= '0;
            aleft_reg  <= '0;
            dleft_reg  <= '0;
            hdr_reg    <= '0;
            cnt_reg    <= '0;
            acc_reg    <= '0;
            res_valid  <= 1'b0;
        end
        else
        begin
            res_valid <= in_fire && rv;
            if (in_fire)
            begin
                phase_reg  <= phase_next;
                offset_reg <= offset_next;
                fcount_reg <= fcount_next;
                label_reg  <= label_next;
                first_reg  <= first_next;
                qleft_reg  <= qleft_next;
                aleft_reg  <= aleft_next;
                dleft_reg  <= dleft_next;
                hdr_reg    <= hdr_next;
                cnt_reg    <= cnt_next;
                acc_reg    <= acc_next;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (in_fire)
            res <= r;
        if (in_fire && tbl_we)
            qstart_mem[qidx[QW-1:0]] <= offset_reg;
    end

    a_onehot: assert property (@(posedge clk) disable iff (!rst_n) $onehot(phase_reg))
        else $error("phase not one-hot");
    a_eom_restart: assert property (@(posedge clk) disable iff (!rst_n)
        in_fire && end_of_message |=> phase_reg == PH_HEADER && offset_reg == '0)
        else $error("no restart after message end");
    a_idle_hold: assert property (@(posedge clk) disable iff (!rst_n)
        !in_fire |=> !res_valid)
        else $error("result without byte");

endmodule

// ===== rtl/core/dmp_queue.sv =====
// ---------------------------------------------------------------------------
// dmp_queue
// small result fifo between parser and output port
// ---------------------------------------------------------------------------
module dmp_queue
    import dmp_pkg::*;
(
    input  logic    clk,
    input  logic    rst_n,
    input  logic    push,
    input  result_t push_data,
    output logic    pop_valid,
    input  logic    pop,
    output result_t pop_data,
    output logic    almost_full
);

    localparam int Depth = 4;

    result_t    mem [Depth];
    logic [1:0] wptr_reg, rptr_reg;
    logic [2:0] cnt_reg;

    assign pop_valid   = cnt_reg != 3'd0;
    assign pop_data    = mem[rptr_reg];
    // one result may already be in flight from the parser
    assign almost_full = cnt_reg >= 3'd3;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wptr_reg <= '0;
            rptr_reg <= '0;
            cnt_reg  <= '0;
        end
        else
        begin
            if (push)
                wptr_reg <= wptr_reg + 2'd1;
            if (pop && pop_valid)
                rptr_reg <= rptr_reg + 2'd1;
            cnt_reg <= cnt_reg + 3'(push) - 3'(pop && pop_valid);
        end
    end

    always_ff @(posedge clk)
    begin
        if (push)
            mem[wptr_reg] <= push_data;
    end

    a_no_over: assert property (@(posedge clk) disable iff (!rst_n)
        push && !pop |-> cnt_reg < 3'd4)
        else $error("queue overflow");
    a_cnt: assert property (@(posedge clk) disable iff (!rst_n) cnt_reg <= 3'd4)
        else $error("bad count");
    a_under: assert property (@(posedge clk) disable iff (!rst_n)
        cnt_reg == 3'd0 && !push |=> cnt_reg == 3'd0)
        else $error("count from nothing");

endmodule
